[rtl/cpc_pkg.sv]
// shared types, constants and controller commands for the clock-pro page cache
package cpc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int DATA_BITS_DEF   = 32;
    localparam int CAP_W           = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request transaction
    typedef struct packed {
        logic        req_type;
        logic [31:0] lookup_key;
        logic [31:0] write_value;
    } t_req;

    // result transaction
    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic [31:0] misses_so_far;
    } t_resp;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_LOOKUP,
        CMD_UPDATE,
        CMD_DEMOTE,
        CMD_SCAN,
        CMD_EVICT,
        CMD_APPEND
    } t_cmd;

    // datapath status
    typedef struct packed {
        logic hit;
        logic hit_cold;
        logic is_put;
        logic full;
        logic demote_go;
        logic scan_stop;
    } t_status;

endpackage

[rtl/cpc_datapath.sv]
// table storage, lookup, demotion, eviction scan and result register
module cpc_datapath #(
    parameter int MAX_ENTRIES = cpc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = cpc_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS   = cpc_pkg::DATA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [cpc_pkg::CAP_W-1:0]   i_cap,
    input  cpc_pkg::t_req               i_req,
    input  cpc_pkg::t_cmd               i_cmd,
    input  logic                        i_load_out,
    output cpc_pkg::t_status            o_status,
    output cpc_pkg::t_resp              o_resp
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [KEY_BITS-1:0]  r_key [MAX_ENTRIES];
    logic [DATA_BITS-1:0] r_val [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_hot;
    logic [MAX_ENTRIES-1:0] r_ref;

    logic [CNT_W-1:0] r_used, r_hot_total, r_cold_total;
    logic [31:0]      r_miss;
    logic             r_is_put;
    logic [KEY_BITS-1:0]  r_req_key;
    logic [DATA_BITS-1:0] r_req_val;
    logic             r_hit;
    logic [IDX_W-1:0] r_idx;
    logic [DATA_BITS-1:0] r_rd;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_victim;
    logic [CNT_W:0]   r_step;
    cpc_pkg::t_resp   r_out;

    logic [63:0]      key_wide, val_wide, rd_wide;
    logic [7:0]       cap_w8;
    logic [CNT_W-1:0] cap_eff, hot_limit;
    logic             match_any;
    logic [IDX_W-1:0] match_idx;
    logic             hot_any;
    logic [IDX_W-1:0] hot_idx;
    logic             scan_bound;
    logic             pos_wrap;

    // input fields cut to storage width
    assign key_wide = 64'(i_req.lookup_key);
    assign val_wide = 64'(i_req.write_value);

    // capacity clamp and hot limit
    always_comb begin
        cap_w8 = 8'(i_cap);
        if (cap_w8 < 8'd1) cap_w8 = 8'd1;
        if (cap_w8 > 8'(MAX_ENTRIES)) cap_w8 = 8'(MAX_ENTRIES);
        cap_eff   = CNT_W'(cap_w8);
        hot_limit = cap_eff >> 1;
    end

    // parallel associative compare, first match wins
    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_used) && (r_key[i] == r_req_key)) begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

    // first hot entry in table order
    always_comb begin
        hot_any = 1'b0;
        hot_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_used) && r_hot[i]) begin
                hot_any = 1'b1;
                hot_idx = IDX_W'(i);
            end
        end
    end

    assign scan_bound = r_step >= {r_used, 1'b0};
    assign pos_wrap   = (CNT_W'(r_pos) + CNT_W'(1)) >= r_used;

    always_comb begin
        o_status.hit       = r_hit;
        o_status.hit_cold  = !r_hot[r_idx];
        o_status.is_put    = r_is_put;
        o_status.full      = r_used >= cap_eff;
        o_status.demote_go = (r_hot_total > hot_limit) && hot_any;
        o_status.scan_stop = scan_bound || (!r_hot[r_pos] && !r_ref[r_pos]);
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            cpc_pkg::CMD_UPDATE: begin
                if (r_hit) begin
                    r_ref[r_idx] <= 1'b1;
                    r_hot[r_idx] <= 1'b1;
                    if (r_is_put) r_val[r_idx] <= r_req_val;
                end
            end
            cpc_pkg::CMD_DEMOTE: begin
                r_hot[hot_idx] <= 1'b0;
            end
            cpc_pkg::CMD_SCAN: begin
                if (!scan_bound && !r_hot[r_pos] && r_ref[r_pos]) r_ref[r_pos] <= 1'b0;
            end
            cpc_pkg::CMD_EVICT: begin
                for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                    if (IDX_W'(i) >= r_victim) begin
                        r_key[i] <= r_key[i+1];
                        r_val[i] <= r_val[i+1];
                        r_hot[i] <= r_hot[i+1];
                        r_ref[i] <= r_ref[i+1];
                    end
                end
            end
            cpc_pkg::CMD_APPEND: begin
                if (r_used < CNT_W'(MAX_ENTRIES)) begin
                    r_key[r_used[IDX_W-1:0]] <= r_req_key;
                    r_val[r_used[IDX_W-1:0]] <= r_req_val;
                    r_hot[r_used[IDX_W-1:0]] <= 1'b0;
                    r_ref[r_used[IDX_W-1:0]] <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // request latch, lookup result, scan pointer and read data
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            cpc_pkg::CMD_LATCH: begin
                r_is_put  <= i_req.req_type == cpc_pkg::REQ_PUT;
                r_req_key <= key_wide[KEY_BITS-1:0];
                r_req_val <= val_wide[DATA_BITS-1:0];
            end
            cpc_pkg::CMD_LOOKUP: begin
                r_hit <= match_any;
                r_idx <= match_idx;
            end
            cpc_pkg::CMD_UPDATE: begin
                r_pos  <= '0;
                r_step <= '0;
                r_rd   <= (r_hit && !r_is_put) ? r_val[r_idx] : '0;
            end
            cpc_pkg::CMD_SCAN: begin
                if (scan_bound) begin
                    r_victim <= '0;
                end else if (!r_hot[r_pos] && !r_ref[r_pos]) begin
                    r_victim <= r_pos;
                end else begin
                    r_pos  <= pos_wrap ? '0 : r_pos + IDX_W'(1);
                    r_step <= r_step + (CNT_W+1)'(1);
                end
            end
            default: ;
        endcase
    end

    // occupancy and miss counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_hot_total  <= '0;
            r_cold_total <= '0;
            r_miss       <= '0;
        end else begin
            unique case (i_cmd)
                cpc_pkg::CMD_UPDATE: begin
                    if (!r_hit) begin
                        r_miss <= r_miss + 32'd1;
                    end else if (!r_hot[r_idx]) begin
                        r_hot_total  <= r_hot_total + CNT_W'(1);
                        r_cold_total <= r_cold_total - CNT_W'(1);
                    end
                end
                cpc_pkg::CMD_DEMOTE: begin
                    r_hot_total  <= r_hot_total - CNT_W'(1);
                    r_cold_total <= r_cold_total + CNT_W'(1);
                end
                cpc_pkg::CMD_EVICT: begin
                    if (r_hot[r_victim]) r_hot_total <= r_hot_total - CNT_W'(1);
                    else r_cold_total <= r_cold_total - CNT_W'(1);
                    r_used <= r_used - CNT_W'(1);
                end
                cpc_pkg::CMD_APPEND: begin
                    if (r_used < CNT_W'(MAX_ENTRIES)) begin
                        r_used       <= r_used + CNT_W'(1);
                        r_cold_total <= r_cold_total + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    assign rd_wide = 64'(r_rd);
    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_out.hit           <= r_hit;
            r_out.read_value    <= rd_wide[31:0];
            r_out.misses_so_far <= r_miss;
        end
    end
    assign o_resp = r_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_ENTRIES))
        else $error("fill count above table size");
    a_marks_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W+1)'(r_hot_total) + (CNT_W+1)'(r_cold_total) == (CNT_W+1)'(r_used))
        else $error("hot and cold totals disagree with fill");
    a_evict_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == cpc_pkg::CMD_EVICT) |=> (r_used == $past(r_used) - CNT_W'(1)))
        else $error("eviction did not remove one entry");
`endif

endmodule

[rtl/cpc_ctrl.sv]
// request sequencer for the clock-pro page cache
module cpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  cpc_pkg::t_status i_status,
    output cpc_pkg::t_cmd    o_cmd,
    output logic             o_load_out
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOOKUP, S_DECIDE, S_DEMOTE, S_SCAN, S_EVICT, S_APPEND, S_RESP
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_load_out  = (r_state == S_RESP) && out_free;

    // command per state
    always_comb begin
        unique case (r_state)
            S_IDLE:   o_cmd = i_in_valid ? cpc_pkg::CMD_LATCH : cpc_pkg::CMD_NONE;
            S_LOOKUP: o_cmd = cpc_pkg::CMD_LOOKUP;
            S_DECIDE: o_cmd = cpc_pkg::CMD_UPDATE;
            S_DEMOTE: o_cmd = i_status.demote_go ? cpc_pkg::CMD_DEMOTE : cpc_pkg::CMD_NONE;
            S_SCAN:   o_cmd = cpc_pkg::CMD_SCAN;
            S_EVICT:  o_cmd = cpc_pkg::CMD_EVICT;
            S_APPEND: o_cmd = cpc_pkg::CMD_APPEND;
            S_RESP:   o_cmd = cpc_pkg::CMD_NONE;
            default:  o_cmd = cpc_pkg::CMD_NONE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= o_load_out || (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_LOOKUP;
                S_LOOKUP: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (i_status.hit) begin
                        r_state <= i_status.hit_cold ? S_DEMOTE : S_RESP;
                    end else if (i_status.is_put) begin
                        r_state <= i_status.full ? S_SCAN : S_APPEND;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_DEMOTE: if (!i_status.demote_go) r_state <= S_RESP;
                S_SCAN:   if (i_status.scan_stop) r_state <= S_EVICT;
                S_EVICT:  r_state <= S_APPEND;
                S_APPEND: r_state <= S_RESP;
                S_RESP: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/clock_pro_page_cache_top.sv]
// top level of the clock-pro page cache
//
// key-value cache with a simplified clock-pro replacement policy.
// request channel i_in_valid / o_in_ready carries a get or put transaction;
// result channel o_out_valid / i_out_ready returns hit, read value and the
// running miss count, one result per request, in order.
// configuration channel i_cfg_valid / o_cfg_ready writes active capacity;
// it is always ready. it must be written only while the block is idle;
// the block itself does not enforce this. one request is in flight at a
// time. a get miss or a hit on a hot entry passes through the lookup,
// decide and response states; a cold hit adds the demote state, which
// demotes hot entries until at most half the capacity is hot; a put miss
// with room adds an append; a put miss on a full table adds a scan for a
// cold unreferenced entry (else the head), an eviction and an append.
// a new request is taken once the sequencer is back to idle, while the last
// result may still wait in its output register.
// a stalled receiver holds the result; the block finishes the next request
// and then waits for the output register to free.
// reset empties the table, clears the miss count and sets capacity to 16.
module clock_pro_page_cache_top #(
    parameter int MAX_ENTRIES = cpc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = cpc_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS   = cpc_pkg::DATA_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  cpc_pkg::t_req             i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output cpc_pkg::t_resp            o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [cpc_pkg::CAP_W-1:0] i_cfg_data
);
    logic [cpc_pkg::CAP_W-1:0] r_cap;
    cpc_pkg::t_status status;
    cpc_pkg::t_cmd    cmd;
    logic             load_out;

    // capacity register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= cpc_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    cpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_load_out  (load_out)
    );

    cpc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .DATA_BITS   (DATA_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cap      (r_cap),
        .i_req      (i_in),
        .i_cmd      (cmd),
        .i_load_out (load_out),
        .o_status   (status),
        .o_resp     (o_out)
    );

endmodule

[test/tb_clock_pro_page_cache_top.sv]
// testbench for the clock-pro page cache: directed and random get/put traffic against a predictor
`timescale 1ns / 100ps

module tb_clock_pro_page_cache_top;

    localparam int SLOTS      = 16;
    localparam int IDLE_LIMIT = 20000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    cpc_pkg::t_req  i_in;
    logic           o_out_valid;
    logic           i_out_ready;
    cpc_pkg::t_resp o_out;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [4:0]     i_cfg_data;

    // predictor state
    logic [31:0] cache_key   [SLOTS];
    logic [31:0] cache_value [SLOTS];
    logic        cache_hot   [SLOTS];
    logic        cache_ref   [SLOTS];
    int          fill;
    int          hot_count;
    logic [31:0] miss_count;
    logic [4:0]  capacity_reg;

    cpc_pkg::t_resp pending_results[$];
    int          error_count;
    int          idle_cycles;
    int          result_count;
    int          hit_count;
    int          evict_count;
    bit          recv_stall_en;

    clock_pro_page_cache_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // drop one table entry and close up the order
    function automatic void cache_remove(input int pos);
        if (cache_hot[pos]) hot_count--;
        for (int i = pos; i < fill - 1; i++) begin
            cache_key[i]   = cache_key[i+1];
            cache_value[i] = cache_value[i+1];
            cache_hot[i]   = cache_hot[i+1];
            cache_ref[i]   = cache_ref[i+1];
        end
        fill--;
    endfunction

    // work out the result of one request and update the predicted table
    function automatic cpc_pkg::t_resp cache_access(input cpc_pkg::t_req req);
        cpc_pkg::t_resp res;
        int    cap;
        int    idx;
        int    pos;
        int    victim;
        bit    found;
        res = '0;
        cap = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS ? SLOTS : int'(capacity_reg));
        idx = -1;
        for (int i = 0; i < fill; i++)
            if (idx < 0 && cache_key[i] == req.lookup_key) idx = i;
        if (idx >= 0) begin
            res.hit = 1'b1;
            hit_count++;
            cache_ref[idx] = 1'b1;
            if (req.req_type == cpc_pkg::REQ_PUT) cache_value[idx] = req.write_value;
            if (!cache_hot[idx]) begin
                cache_hot[idx] = 1'b1;
                hot_count++;
                // demote first hot entries in table order
                while (hot_count > cap / 2) begin
                    found = 0;
                    for (int i = 0; i < fill && !found; i++)
                        if (cache_hot[i]) begin
                            cache_hot[i] = 1'b0;
                            hot_count--;
                            found = 1;
                        end
                    if (!found) break;
                end
            end
            if (req.req_type == cpc_pkg::REQ_GET) res.read_value = cache_value[idx];
        end else begin
            miss_count++;
            if (req.req_type == cpc_pkg::REQ_PUT) begin
                if (fill >= cap && fill > 0) begin
                    // bounded clock scan over cold entries
                    pos = 0;
                    victim = 0;
                    found = 0;
                    for (int s = 0; s < 2 * fill && !found; s++) begin
                        if (!cache_hot[pos]) begin
                            if (cache_ref[pos]) cache_ref[pos] = 1'b0;
                            else begin
                                victim = pos;
                                found = 1;
                            end
                        end
                        if (!found) pos = (pos + 1 >= fill) ? 0 : pos + 1;
                    end
                    cache_remove(victim);
                    evict_count++;
                end
                if (fill < SLOTS) begin
                    cache_key[fill]   = req.lookup_key;
                    cache_value[fill] = req.write_value;
                    cache_hot[fill]   = 1'b0;
                    cache_ref[fill]   = 1'b1;
                    fill++;
                end
            end
        end
        res.misses_so_far = miss_count;
        return res;
    endfunction

    // send one request transaction after a random gap
    task automatic send_request(input logic op, input logic [31:0] key, input logic [31:0] val);
        cpc_pkg::t_req req;
        int   gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.req_type    = op;
        req.lookup_key  = key;
        req.write_value = val;
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(cache_access(req));
    endtask

    // wait until every expected result has arrived, then for the block to settle
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // write the capacity register while idle
    task automatic write_capacity(input logic [4:0] cap);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        capacity_reg = cap;
        i_cfg_valid <= 1'b0;
    endtask

    // result checker and receiver stalls
    initial begin
        cpc_pkg::t_resp exp_res;
        int    stall;
        @(posedge i_clk);
        forever begin
            stall = recv_stall_en ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            result_count++;
            if (pending_results.size() == 0) begin
                $error("result transaction with no request outstanding");
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out.hit !== exp_res.hit) begin
                    $error("hit: expected %0d, got %0d", exp_res.hit, o_out.hit);
                    error_count++;
                end
                if (o_out.read_value !== exp_res.read_value) begin
                    $error("read_value: expected %0h, got %0h",
                           exp_res.read_value, o_out.read_value);
                    error_count++;
                end
                if (o_out.misses_so_far !== exp_res.misses_so_far) begin
                    $error("misses_so_far: expected %0d, got %0d",
                           exp_res.misses_so_far, o_out.misses_so_far);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // extremes of the fields, hit and miss of each kind
    task automatic test_directed;
        send_request(cpc_pkg::REQ_GET, 32'h0, 32'h0);
        send_request(cpc_pkg::REQ_PUT, 32'h0, 32'hFFFF_FFFF);
        send_request(cpc_pkg::REQ_GET, 32'h0, 32'h1234_5678);
        send_request(cpc_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'h0);
        send_request(cpc_pkg::REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(cpc_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_request(cpc_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(cpc_pkg::REQ_GET, 32'h5555_5555, 32'h0);
        send_request(cpc_pkg::REQ_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(cpc_pkg::REQ_PUT, 32'h0, 32'hAAAA_AAAA);
    endtask

    // fill past a small capacity so that evictions and demotions happen
    task automatic test_eviction(input logic [4:0] cap, input int keys);
        write_capacity(cap);
        for (int i = 0; i < keys; i++)
            send_request(cpc_pkg::REQ_PUT, 32'h100 + i, $urandom);
        for (int i = 0; i < keys; i++)
            send_request(cpc_pkg::REQ_GET, 32'h100 + i, $urandom);
    endtask

    // a hot entry at the head so the scan passes over it and evicts the cold entry behind it
    task automatic test_all_hot;
        write_capacity(5'd2);
        send_request(cpc_pkg::REQ_PUT, 32'h200, 32'h1);
        send_request(cpc_pkg::REQ_GET, 32'h200, 32'h0);
        send_request(cpc_pkg::REQ_PUT, 32'h201, 32'h2);
        send_request(cpc_pkg::REQ_PUT, 32'h202, 32'h3);
    endtask

    // random traffic over a small key pool so hits are common
    task automatic test_random(input int count);
        logic [31:0] key;
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0) write_capacity(5'($urandom_range(0, 31)));
            if ($urandom_range(0, 9) == 0) key = $urandom;
            else key = $urandom_range(0, 23) ^ {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'h0};
            send_request(1'($urandom_range(0, 1)), key, $urandom);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        fill         = 0;
        hot_count    = 0;
        miss_count   = '0;
        capacity_reg = cpc_pkg::CAP_RESET;
        error_count  = 0;
        result_count = 0;
        hit_count    = 0;
        evict_count  = 0;
        recv_stall_en = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_eviction(5'd1, 3);
        test_eviction(5'd0, 3);
        test_eviction(5'd31, 20);
        test_eviction(5'd4, 8);
        test_all_hot();
        test_eviction(5'd16, 18);
        // lowered below the fill
        test_eviction(5'd3, 6);
        recv_stall_en = 1'b0;
        test_random(300);
        recv_stall_en = 1'b1;
        test_random(1700);
        drain();

        $display("covered %0d results, %0d hits, %0d evictions, capacities 0 to 31",
                 result_count, hit_count, evict_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
